>>> rtl/core/gww_pkg.sv
// types, constants and codes shared by the word wrap block
package gww_pkg;

    localparam int MAX_LINES       = 64;
    localparam int MAX_BLOCK_CHARS = 4096;

    localparam int POS_W    = 13;
    localparam int COL_W    = 11;
    localparam int FW_W     = 5;
    localparam int LCNT_W   = $clog2(MAX_LINES + 1);
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef enum logic [2:0] {
        KIND_PARA    = 3'd0,
        KIND_HEADING = 3'd1,
        KIND_LIST    = 3'd2,
        KIND_QUOTE   = 3'd3,
        KIND_PRE     = 3'd4
    } kind_code_t;

    typedef enum logic [1:0] {
        CFG_BODY_CW = 2'd0,
        CFG_HEAD_CW = 2'd1,
        CFG_CONTENT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        logic       empty_block;
        logic [2:0] block_kind;
        logic [3:0] nest_level;
    } in_beat_t;

    typedef struct packed {
        logic [12:0] start_pos;
        logic [12:0] line_end;
        logic [5:0]  line_number;
        logic        final_line;
    } out_beat_t;

    typedef struct packed {
        logic [4:0]  body_char_width;
        logic [4:0]  head_char_width;
        logic [10:0] content_width;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       ch;
        logic             first;
        logic             last;
        logic             empty_block;
        logic             pre;
        logic [COL_W-1:0] columns;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> rtl/core/gww_front.sv
// front end: beat intake, block classification and column division
module gww_front import gww_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    input  q_status_t q_status,
    output logic      q_push,
    output q_entry_t  q_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [COL_W-1:0] columns_reg, columns_next;
    in_beat_t         item_reg;
    logic [COL_W-1:0] dq_reg, dq_next;
    logic [FW_W:0]    rem_reg, rem_next;
    logic [FW_W-1:0]  fw_reg;
    logic [3:0]       cnt_reg, cnt_next;

    logic [FW_W-1:0]  bw, hw, fw;
    logic [5:0]       mult;
    logic [10:0]      ind;
    logic [11:0]      diff;
    logic [COL_W-1:0] tw;
    logic [FW_W:0]    trial;
    logic             accept, starts_block;

    assign bw = (cfg.body_char_width == '0) ? FW_W'(1) : cfg.body_char_width;
    assign hw = (cfg.head_char_width == '0) ? FW_W'(1) : cfg.head_char_width;
    assign fw = (s_data.block_kind == KIND_HEADING) ? hw : bw;

    always_comb begin
        unique case (s_data.block_kind)
            KIND_LIST:  mult = {1'b0, s_data.nest_level, 1'b0} + 6'd3;
            KIND_QUOTE: mult = (s_data.nest_level == '0) ? 6'd2
                                                         : {1'b0, s_data.nest_level, 1'b0};
            KIND_PRE:   mult = 6'd2;
            default:    mult = 6'd0;
        endcase
    end

    assign ind  = 11'(mult) * 11'(bw);
    assign diff = {1'b0, cfg.content_width} - {1'b0, ind};
    assign tw   = (diff[11] || (diff[10:0] < {6'd0, fw})) ? {6'd0, fw} : diff[10:0];

    assign s_ready      = (state_reg == ST_IDLE) && !q_status.full;
    assign accept       = s_valid && s_ready;
    assign starts_block = s_data.first || s_data.empty_block;
    assign trial        = {rem_reg[FW_W-1:0], dq_reg[COL_W-1]};

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        columns_next = columns_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        q_push       = 1'b0;
        q_wdata.ch          = s_data.ch;
        q_wdata.first       = s_data.first;
        q_wdata.last        = s_data.last;
        q_wdata.empty_block = s_data.empty_block;
        q_wdata.pre         = (kind_reg == KIND_PRE);
        q_wdata.columns     = columns_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (starts_block) begin
                        kind_next  = s_data.block_kind;
                        dq_next    = tw;
                        rem_next   = '0;
                        cnt_next   = 4'(COL_W);
                        state_next = ST_DIV;
                    end else begin
                        q_push = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, fw_reg}) begin
                    rem_next = trial - {1'b0, fw_reg};
                    dq_next  = {dq_reg[COL_W-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    dq_next  = {dq_reg[COL_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                columns_next        = dq_reg;
                q_wdata.ch          = item_reg.ch;
                q_wdata.first       = item_reg.first;
                q_wdata.last        = item_reg.last;
                q_wdata.empty_block = item_reg.empty_block;
                q_wdata.columns     = dq_reg;
                if (!q_status.full) begin
                    q_push     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            kind_reg    <= KIND_PARA;
            columns_reg <= COL_W'(1);
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            columns_reg <= columns_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (accept) begin
            item_reg <= s_data;
            fw_reg   <= fw;
        end
    end

endmodule

>>> rtl/core/gww_queue.sv
// short queue of classified beats between front and back
module gww_queue import gww_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_entry_t  wdata,
    input  logic      pop,
    output q_entry_t  rdata,
    output q_status_t status
);

    q_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, rd_reg;
    logic [Q_PTR_W:0]   cnt_reg;

    assign status.full  = (cnt_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign rdata        = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + (Q_PTR_W + 1)'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - (Q_PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/gww_back.sv
// back end: line breaking state and result beat buffer
module gww_back import gww_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  q_entry_t  q_rdata,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  cls_reg, cls_next;
    logic [POS_W-1:0]  lsp_reg, lsp_next;
    logic              skip_reg, skip_next;
    logic [LCNT_W-1:0] le_reg, le_next;
    out_beat_t         res0_reg, res1_reg, res0_next, res1_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              rd_reg, rd_next;

    logic [POS_W-1:0]  p;
    logic              a_vld, b_vld;
    logic [POS_W-1:0]  a_s, a_e, b_s, b_e;
    logic [1:0]        n;
    logic              is_space;
    logic              fire;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_data   = rd_reg ? res1_reg : res0_reg;
    assign fire     = m_valid && m_ready;
    assign q_pop    = !q_status.empty && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready));
    assign is_space = (q_rdata.ch == SPACE_CHAR);

    always_comb begin
        pos_next  = pos_reg;
        cls_next  = cls_reg;
        lsp_next  = lsp_reg;
        skip_next = skip_reg;
        le_next   = le_reg;
        a_vld = 1'b0;
        b_vld = 1'b0;
        a_s   = '0;
        a_e   = '0;
        b_s   = '0;
        b_e   = '0;
        n     = 2'd0;
        p     = '0;
        res0_next = res0_reg;
        res1_next = res1_reg;

        if (q_rdata.empty_block) begin
            b_vld     = 1'b1;
            pos_next  = '0;
            cls_next  = '0;
            lsp_next  = '0;
            skip_next = 1'b0;
            le_next   = '0;
        end else begin
            if (q_rdata.first) begin
                pos_next  = '0;
                cls_next  = '0;
                lsp_next  = '0;
                skip_next = 1'b0;
                le_next   = '0;
            end
            p = pos_next;
            if (p < POS_W'(MAX_BLOCK_CHARS)) begin
                if (!q_rdata.pre) begin
                    if (skip_next) begin
                        if (!is_space) begin
                            a_vld     = 1'b1;
                            a_s       = cls_next;
                            a_e       = lsp_next;
                            cls_next  = p;
                            lsp_next  = '0;
                            skip_next = 1'b0;
                        end
                    end else if ({1'b0, p} >= ({1'b0, cls_next}
                                               + {3'd0, q_rdata.columns})) begin
                        if (is_space) begin
                            lsp_next  = p;
                            skip_next = 1'b1;
                        end else if (lsp_next != '0) begin
                            a_vld    = 1'b1;
                            a_s      = cls_next;
                            a_e      = lsp_next;
                            cls_next = lsp_next + POS_W'(1);
                            lsp_next = '0;
                        end else begin
                            a_vld    = 1'b1;
                            a_s      = cls_next;
                            a_e      = p;
                            cls_next = p;
                            lsp_next = '0;
                        end
                    end else if (is_space && (p > cls_next)) begin
                        lsp_next = p;
                    end
                end
                pos_next = p + POS_W'(1);
            end
            if (q_rdata.last) begin
                b_vld = 1'b1;
                if (q_rdata.pre) begin
                    b_s = '0;
                    b_e = pos_next;
                end else if (skip_next) begin
                    b_s = cls_next;
                    b_e = lsp_next;
                end else begin
                    b_s = cls_next;
                    b_e = pos_next;
                end
                pos_next  = '0;
                cls_next  = '0;
                lsp_next  = '0;
                skip_next = 1'b0;
            end
        end

        // line limit applies in emission order
        if (a_vld && (le_next < LCNT_W'(MAX_LINES))) begin
            res0_next.start_pos   = a_s;
            res0_next.line_end    = a_e;
            res0_next.line_number = le_next[5:0];
            res0_next.final_line  = (le_next + LCNT_W'(1) == LCNT_W'(MAX_LINES));
            le_next = le_next + LCNT_W'(1);
            n = 2'd1;
        end
        if (b_vld && (le_next < LCNT_W'(MAX_LINES))) begin
            if (n == 2'd0) begin
                res0_next.start_pos   = b_s;
                res0_next.line_end    = b_e;
                res0_next.line_number = le_next[5:0];
                res0_next.final_line  = 1'b1;
            end else begin
                res1_next.start_pos   = b_s;
                res1_next.line_end    = b_e;
                res1_next.line_number = le_next[5:0];
                res1_next.final_line  = 1'b1;
            end
            n = n + 2'd1;
        end
        if (b_vld) begin
            le_next = '0;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (fire) begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = 1'b1;
        end
        if (q_pop) begin
            cnt_next = n;
            rd_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            cls_reg  <= '0;
            lsp_reg  <= '0;
            skip_reg <= 1'b0;
            le_reg   <= '0;
            cnt_reg  <= 2'd0;
            rd_reg   <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            if (q_pop) begin
                pos_reg  <= pos_next;
                cls_reg  <= cls_next;
                lsp_reg  <= lsp_next;
                skip_reg <= skip_next;
                le_reg   <= le_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res0_reg <= res0_next;
            res1_reg <= res1_next;
        end
    end

endmodule

>>> rtl/core/greedy_word_wrap.sv
// top level of the greedy word wrap block with its configuration registers
//
// s_ channel: one character beat per handshake; the first beat of a block
// carries its kind and nesting level, an empty-block beat is a whole block.
// m_ channel: one display line per beat (start, exclusive end, line number,
// final flag); a character beat gives zero, one or two line beats.
// cfg_ channel: register index 0 body char width, 1 heading char width,
// 2 content width; always ready. The user must see that the registers are
// written only while the block is idle; the block does not enforce this.
// Throughput: one character beat per cycle inside a block while the queue
// has room. A first or empty-block beat holds the intake while the column
// count is found by an 11-step restoring divider in the front end.
// An accepted character beat is registered in the queue and then in the
// result buffer before its first line beat; a first or empty-block beat
// passes the divider first. A beat with two lines shows them in turn.
// A four-entry queue parts front and back, so when the receiver stalls,
// beats keep flowing in until the queue fills, then s_ready drops.
// Reset (synchronous, aresetn low) empties the queue and result buffer and
// restores register defaults 5, 6 and 640.
module greedy_word_wrap import gww_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      q_push, q_pop;
    q_entry_t  q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.body_char_width <= 5'd5;
            cfg_reg.head_char_width <= 5'd6;
            cfg_reg.content_width   <= 11'd640;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BODY_CW: cfg_reg.body_char_width <= cfg_data[4:0];
                CFG_HEAD_CW: cfg_reg.head_char_width <= cfg_data[4:0];
                CFG_CONTENT: cfg_reg.content_width   <= cfg_data;
                default: ;
            endcase
        end
    end

    gww_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    gww_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    gww_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
